// ===== rtl/glcd_pkg.sv =====
// Shared types and codes for the graphic LCD bus cycle sequencer.
`default_nettype none

package glcd_pkg;

  localparam int unsigned STEP_W = 3;

  // Request kinds
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Bus cycle kinds
  localparam logic [2:0] KIND_BUSY   = 3'd0;
  localparam logic [2:0] KIND_INSTR  = 3'd1;
  localparam logic [2:0] KIND_DWRITE = 3'd2;
  localparam logic [2:0] KIND_DUMMY  = 3'd3;
  localparam logic [2:0] KIND_DREAD  = 3'd4;
  localparam logic [2:0] KIND_RESET  = 3'd5;

  // Controller instructions
  localparam logic [7:0] INSTR_DISPLAY_ON = 8'h3F;
  localparam logic [7:0] INSTR_SET_Y      = 8'h40;
  localparam logic [7:0] INSTR_SET_PAGE   = 8'hB8;
  localparam logic [7:0] INSTR_START_LINE = 8'hC0;

  // Step positions within a run
  localparam logic [STEP_W-1:0] STEP_0 = 3'd0;
  localparam logic [STEP_W-1:0] STEP_1 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_2 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_3 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_4 = 3'd4;
  localparam logic [STEP_W-1:0] STEP_5 = 3'd5;
  localparam logic [STEP_W-1:0] STEP_6 = 3'd6;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] write_byte;
  } glcd_req_t;

  typedef struct packed {
    logic [2:0] cycle_kind;
    logic       chip_one_select;
    logic       chip_two_select;
    logic       register_select;
    logic       read_not_write;
    logic [7:0] bus_byte;
    logic       last_cycle;
  } glcd_cycle_t;

endpackage

`default_nettype wire

// ===== rtl/glcd_cycle_decode.sv =====
// Maps a request and a step position to the bus cycle emitted at that step.
`default_nettype none

module glcd_cycle_decode (
  input  glcd_pkg::glcd_req_t            req,
  input  logic [glcd_pkg::STEP_W-1:0]    step,
  output glcd_pkg::glcd_cycle_t          cycle
);
  import glcd_pkg::*;

  logic cs1;

  assign cs1 = ~req.column[6];

  always_comb begin
    // Default: busy wait on both chips
    cycle                 = '0;
    cycle.cycle_kind      = KIND_BUSY;
    cycle.chip_one_select = 1'b1;
    cycle.chip_two_select = 1'b1;
    cycle.read_not_write  = 1'b1;
    if (req.opcode == OP_INIT) begin
      cycle.read_not_write = 1'b0;
      cycle.cycle_kind     = KIND_INSTR;
      case (step)
        STEP_0: begin
          cycle.cycle_kind = KIND_RESET;
        end
        STEP_1: cycle.bus_byte = INSTR_DISPLAY_ON;
        STEP_2: cycle.bus_byte = INSTR_SET_Y;
        STEP_3: cycle.bus_byte = INSTR_SET_PAGE;
        default: begin
          cycle.bus_byte   = INSTR_START_LINE;
          cycle.last_cycle = 1'b1;
        end
      endcase
    end else begin
      case (step)
        STEP_0, STEP_2, STEP_4: begin
        end
        STEP_1: begin
          cycle.cycle_kind     = KIND_INSTR;
          cycle.read_not_write = 1'b0;
          cycle.bus_byte       = INSTR_SET_PAGE + {5'd0, req.page};
        end
        STEP_3: begin
          cycle.cycle_kind     = KIND_INSTR;
          cycle.read_not_write = 1'b0;
          cycle.bus_byte       = INSTR_SET_Y + {2'd0, req.column[5:0]};
        end
        STEP_5: begin
          cycle.chip_one_select = cs1;
          cycle.chip_two_select = ~cs1;
          cycle.register_select = 1'b1;
          if (req.opcode == OP_WRITE) begin
            cycle.cycle_kind     = KIND_DWRITE;
            cycle.read_not_write = 1'b0;
            cycle.bus_byte       = req.write_byte;
            cycle.last_cycle     = 1'b1;
          end else begin
            cycle.cycle_kind = KIND_DUMMY;
          end
        end
        default: begin
          cycle.chip_one_select = cs1;
          cycle.chip_two_select = ~cs1;
          cycle.register_select = 1'b1;
          cycle.cycle_kind      = KIND_DREAD;
          cycle.last_cycle      = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/glcd_bus_cycle_sequencer.sv =====
// Top level: request register, step counter and output register for the LCD bus sequencer.
`default_nettype none

// Takes one request (initialize, write byte, read byte) for a two-chip 128x64
// graphic LCD and emits its bus cycles as words on the out_ channel, one word
// per clock when the sink does not stall. Initialize gives 5 words, write 6,
// read 7; the step counter over the held request sets that figure. The next
// request is taken in the clock in which the last word of the current run
// loads into the output register, so runs follow each other with no gap.
// Opcode 3 is taken and dropped without any word.
module glcd_bus_cycle_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  glcd_pkg::glcd_req_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output glcd_pkg::glcd_cycle_t out_data
);
  import glcd_pkg::*;

  logic              req_valid_r;
  glcd_req_t         req_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  glcd_cycle_t       out_r;

  glcd_cycle_t       cycle;
  logic              out_load;
  logic              run_done;
  logic              in_take;

  glcd_cycle_decode u_decode (
    .req   (req_r),
    .step  (step_r),
    .cycle (cycle)
  );

  assign out_load = req_valid_r && (!out_valid_r || !out_stall);
  assign run_done = out_load && cycle.last_cycle;
  assign in_stall = req_valid_r && !run_done;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      step_r      <= STEP_0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        // drop the unused opcode here
        req_valid_r <= (in_data.opcode != OP_NONE);
        step_r      <= STEP_0;
      end else if (run_done) begin
        req_valid_r <= 1'b0;
        step_r      <= STEP_0;
      end else if (out_load) begin
        step_r <= step_r + STEP_1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_r <= cycle;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== verif/tb_glcd_bus_cycle_sequencer.sv =====
// Self-checking testbench for the graphic LCD bus cycle sequencer.
module tb_glcd_bus_cycle_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import glcd_pkg::*;

  localparam int RAND_ITEMS     = 450;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_TAIL     = 20;

  typedef struct {
    glcd_req_t   req;
    bit          pinned;
    glcd_cycle_t last_word;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  glcd_req_t   in_data   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  glcd_cycle_t out_data;

  glcd_cycle_t bus_cycle_q[$];
  dir_row_t    dir_tbl[$];
  glcd_cycle_t due_word;
  int          fail_count  = 0;
  int          idle_cycles = 0;
  bit          hold_req    = 1'b0;
  int          hold_left   = 0;
  logic [1:0]  stall_mode  = 2'd0;
  logic [15:0] stall_tick  = '0;

  glcd_bus_cycle_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic glcd_req_t mk_req(logic [1:0] op, logic [2:0] pg, logic [6:0] col,
                                       logic [7:0] wb);
    glcd_req_t r;
    r.opcode     = op;
    r.page       = pg;
    r.column     = col;
    r.write_byte = wb;
    return r;
  endfunction

  function automatic glcd_cycle_t mk_word(logic [2:0] kind, logic cs1, logic cs2, logic rs,
                                          logic rw, logic [7:0] b, logic last);
    glcd_cycle_t w;
    w.cycle_kind      = kind;
    w.chip_one_select = cs1;
    w.chip_two_select = cs2;
    w.register_select = rs;
    w.read_not_write  = rw;
    w.bus_byte        = b;
    w.last_cycle      = last;
    return w;
  endfunction

  // Queue the bus cycles that one request expands into.
  function automatic void expand_request(glcd_req_t r);
    glcd_cycle_t run [0:6];
    glcd_cycle_t w;
    int          n;
    logic        left;
    n    = 0;
    left = (r.column < 7'd64);
    if (r.opcode == OP_INIT) begin
      run[0] = mk_word(KIND_RESET, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
      run[1] = mk_word(KIND_INSTR, 1'b1, 1'b1, 1'b0, 1'b0, INSTR_DISPLAY_ON, 1'b0);
      run[2] = mk_word(KIND_INSTR, 1'b1, 1'b1, 1'b0, 1'b0, INSTR_SET_Y, 1'b0);
      run[3] = mk_word(KIND_INSTR, 1'b1, 1'b1, 1'b0, 1'b0, INSTR_SET_PAGE, 1'b0);
      run[4] = mk_word(KIND_INSTR, 1'b1, 1'b1, 1'b0, 1'b0, INSTR_START_LINE, 1'b0);
      n = 5;
    end else if (r.opcode == OP_WRITE || r.opcode == OP_READ) begin
      run[0] = mk_word(KIND_BUSY, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
      run[1] = mk_word(KIND_INSTR, 1'b1, 1'b1, 1'b0, 1'b0,
                       INSTR_SET_PAGE + {5'd0, r.page}, 1'b0);
      run[2] = run[0];
      run[3] = mk_word(KIND_INSTR, 1'b1, 1'b1, 1'b0, 1'b0,
                       INSTR_SET_Y + {2'd0, r.column[5:0]}, 1'b0);
      run[4] = run[0];
      if (r.opcode == OP_WRITE) begin
        run[5] = mk_word(KIND_DWRITE, left, ~left, 1'b1, 1'b0, r.write_byte, 1'b0);
        n = 6;
      end else begin
        run[5] = mk_word(KIND_DUMMY, left, ~left, 1'b1, 1'b1, 8'h00, 1'b0);
        run[6] = mk_word(KIND_DREAD, left, ~left, 1'b1, 1'b1, 8'h00, 1'b0);
        n = 7;
      end
    end
    for (int i = 0; i < n; i++) begin
      w            = run[i];
      w.last_cycle = (i == n - 1);
      bus_cycle_q.push_back(w);
    end
  endfunction

  task automatic add_row(glcd_req_t r, bit pinned, glcd_cycle_t w);
    dir_row_t row;
    row.req       = r;
    row.pinned    = pinned;
    row.last_word = w;
    dir_tbl.push_back(row);
  endtask

  // Offer one request; return at the edge that accepts it, valid still high.
  task automatic send_req(glcd_req_t r, bit pinned, glcd_cycle_t w);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expand_request(r);
    if (pinned) begin
      void'(bus_cycle_q.pop_back());
      bus_cycle_q.push_back(w);
    end
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bus_cycle_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_data);
        fail_count++;
      end else begin
        due_word = bus_cycle_q.pop_front();
        check_field("cycle_kind", 8'(due_word.cycle_kind), 8'(out_data.cycle_kind));
        check_field("chip_one_select", 8'(due_word.chip_one_select),
                    8'(out_data.chip_one_select));
        check_field("chip_two_select", 8'(due_word.chip_two_select),
                    8'(out_data.chip_two_select));
        check_field("register_select", 8'(due_word.register_select),
                    8'(out_data.register_select));
        check_field("read_not_write", 8'(due_word.read_not_write),
                    8'(out_data.read_not_write));
        check_field("bus_byte", due_word.bus_byte, out_data.bus_byte);
        check_field("last_cycle", 8'(due_word.last_cycle), 8'(out_data.last_cycle));
      end
    end
  end

  // Sink stall: pick a new random pattern when the low six bits of stall_tick are zero; a hold request wins over all.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[5:0] == 6'd0)
      stall_mode <= 2'($urandom_range(0, 3));
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      case (stall_mode)
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= (stall_tick[2:0] < 3'd3);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    glcd_req_t r;
    int        sent;
    int        burst;
    int        pick;
    bit        drained;
    bit        held;
    sent    = 0;
    drained = 1'b0;
    held    = 1'b0;

    add_row(mk_req(OP_INIT, 3'd0, 7'd0, 8'h00), 1'b1,
            mk_word(KIND_INSTR, 1'b1, 1'b1, 1'b0, 1'b0, INSTR_START_LINE, 1'b1));
    add_row(mk_req(OP_INIT, 3'd7, 7'd127, 8'hFF), 1'b1,
            mk_word(KIND_INSTR, 1'b1, 1'b1, 1'b0, 1'b0, INSTR_START_LINE, 1'b1));
    add_row(mk_req(OP_WRITE, 3'd0, 7'd0, 8'h00), 1'b1,
            mk_word(KIND_DWRITE, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1));
    add_row(mk_req(OP_WRITE, 3'd7, 7'd127, 8'hFF), 1'b1,
            mk_word(KIND_DWRITE, 1'b0, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b1));
    add_row(mk_req(OP_WRITE, 3'd3, 7'd63, 8'hA5), 1'b1,
            mk_word(KIND_DWRITE, 1'b1, 1'b0, 1'b1, 1'b0, 8'hA5, 1'b1));
    add_row(mk_req(OP_WRITE, 3'd4, 7'd64, 8'h5A), 1'b1,
            mk_word(KIND_DWRITE, 1'b0, 1'b1, 1'b1, 1'b0, 8'h5A, 1'b1));
    add_row(mk_req(OP_READ, 3'd0, 7'd0, 8'hFF), 1'b1,
            mk_word(KIND_DREAD, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1));
    add_row(mk_req(OP_READ, 3'd7, 7'd127, 8'h00), 1'b1,
            mk_word(KIND_DREAD, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1));
    add_row(mk_req(OP_READ, 3'd5, 7'd63, 8'h3C), 1'b0, '0);
    add_row(mk_req(OP_READ, 3'd2, 7'd64, 8'hC3), 1'b0, '0);
    // Unused opcode: no bus cycles at all.
    add_row(mk_req(OP_NONE, 3'd7, 7'd127, 8'hFF), 1'b0, '0);
    add_row(mk_req(OP_NONE, 3'd0, 7'd0, 8'h00), 1'b0, '0);
    add_row(mk_req(OP_INIT, 3'd5, 7'd42, 8'h99), 1'b0, '0);
    add_row(mk_req(OP_WRITE, 3'd1, 7'd1, 8'h01), 1'b0, '0);
    add_row(mk_req(OP_WRITE, 3'd2, 7'd32, 8'h80), 1'b0, '0);
    add_row(mk_req(OP_NONE, 3'd3, 7'd85, 8'h55), 1'b0, '0);
    add_row(mk_req(OP_WRITE, 3'd6, 7'd96, 8'h7E), 1'b0, '0);
    add_row(mk_req(OP_WRITE, 3'd5, 7'd65, 8'h81), 1'b0, '0);
    add_row(mk_req(OP_READ, 3'd6, 7'd126, 8'h55), 1'b0, '0);
    add_row(mk_req(OP_READ, 3'd1, 7'd16, 8'hAA), 1'b0, '0);
    add_row(mk_req(OP_WRITE, 3'd7, 7'd62, 8'h10), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      send_req(dir_tbl[i].req, dir_tbl[i].pinned, dir_tbl[i].last_word);
      if ($urandom_range(0, 3) == 0)
        idle_gap($urandom_range(1, 6));
    end

    while (sent < RAND_ITEMS) begin
      if (!drained && sent >= 150) begin
        // Hold the sender until the block has flushed every word.
        in_valid <= 1'b0;
        while (bus_cycle_q.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      if (!held && sent >= 300) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        r.opcode     = (pick < 15) ? OP_INIT : (pick < 55) ? OP_WRITE :
                       (pick < 92) ? OP_READ : OP_NONE;
        r.page       = 3'($urandom_range(0, 7));
        r.column     = 7'($urandom_range(0, 127));
        r.write_byte = 8'($urandom_range(0, 255));
        send_req(r, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 2) != 0)
        idle_gap($urandom_range(1, 10));
    end

    in_valid <= 1'b0;
    while (bus_cycle_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
